[rtl/core/gbd_pkg.sv]
// Package: types and constants of the GSM burst datagram deframer.
package gbd_pkg;

    typedef enum logic [2:0] {
        ST_BURST    = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_FCCH_SCH = 3'd2,
        ST_DUMMY    = 3'd3,
        ST_OTHER_TS = 3'd4
    } t_status;

    localparam logic [7:0] DATAGRAM_LEN = 8'd154;
    localparam logic [7:0] HEADER_LEN   = 8'd6;
    localparam logic [7:0] BYTE_MAX     = 8'd255;
    localparam logic [7:0] PACK_LO_FIRST = 8'd3;
    localparam logic [7:0] PACK_LO_LAST  = 8'd60;
    localparam logic [7:0] PACK_HI_FIRST = 8'd87;
    localparam logic [7:0] PACK_HI_LAST  = 8'd144;
    localparam logic [7:0] PACK_HI_SHIFT = 8'd29;
    localparam logic [6:0] PACK_LAST_BIT = 7'd115;
    localparam logic [3:0] PACK_LAST_IDX = 4'd14;
    localparam int         PACKED_LEN    = 15;

    localparam logic [8:0] MOD51_X1 = 9'd51;
    localparam logic [8:0] MOD51_X2 = 9'd102;
    localparam logic [8:0] MOD51_X3 = 9'd153;

    // Dummy burst bit pattern, bit 0 first.
    localparam logic [0:147] DUMMY_BITS = {
        3'b000,
        32'b1111_1011_0111_0110_0000_1010_0100_1110,
        32'b0000_1001_0001_0000_0001_1111_0001_1100,
        32'b0101_1100_0101_1100_0101_0111_0100_1010,
        32'b0011_0011_0011_1001_1110_1001_1111_0001,
        14'b0010_1111_1010_10,
        3'b000
    };

    // (fn mod 51) mod 10 < 2, for a residue below 51.
    function automatic logic is_fcch_sch(input logic [5:0] m);
        logic r;
        case (m)
            6'd0, 6'd1, 6'd10, 6'd11, 6'd20, 6'd21,
            6'd30, 6'd31, 6'd40, 6'd41, 6'd50: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/gsm_burst_datagram_deframer_unit.sv]
// Top level: GSM burst datagram deframer with packed burst store in a RAM.
//
//  channel  dir  handshake                  payload
//  s        in   i_s_tvalid / o_s_tready    tdata rx_byte, tlast end_of_datagram
//  m        out  o_m_tvalid / i_m_tready    tdata fn/slot/power/byte/index,
//                                           tuser status, tlast last_of_run
//  cfg      in   i_cfg_valid / o_cfg_ready  accepted_timeslot
//
// One input byte per cycle; packed bytes are written whole to a 15 x 8 RAM.
// At the final byte a result request is queued; status gives one item, a burst
// gives 15 items, one per cycle while not stalled, read from a registered RAM port.
// Input stalls at a final byte while a queued request is not leaving that cycle,
// or when a write would hit a RAM entry that the current burst has not read out yet.
// Synchronous active-low reset clears counters, header fields, timeslot and handshake state; no sweep.
module gsm_burst_datagram_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] frame_number, [39:32] timeslot,
                                     // [47:40] power_attenuation, [55:48] burst_byte,
                                     // [59:56] byte_index, [63:60] zero
    output logic [2:0]  o_m_tuser,   // [2:0] status
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    logic [7:0] r_mem [gbd_pkg::PACKED_LEN];
    logic [7:0] r_mem_q;

    logic [2:0]  r_ts;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_slot, n_slot;
    logic [31:0] r_fn, n_fn;
    logic [5:0]  r_mod, n_mod;
    logic [7:0]  r_pwr, n_pwr;
    logic        r_dummy, n_dummy;
    logic [7:0]  r_acc, n_acc;

    logic            r_job_vld, n_job_vld;
    gbd_pkg::t_status r_job_st, n_job_st;
    logic [31:0]     r_job_fn, n_job_fn;
    logic [7:0]      r_job_slot, n_job_slot;
    logic [7:0]      r_job_pwr, n_job_pwr;
    logic [3:0]      r_rd_idx, n_rd_idx;

    logic            r_out_vld, n_out_vld;
    logic [2:0]      r_out_st, n_out_st;
    logic [31:0]     r_out_fn, n_out_fn;
    logic [7:0]      r_out_slot, n_out_slot;
    logic [7:0]      r_out_pwr, n_out_pwr;
    logic [7:0]      r_out_byte, n_out_byte;
    logic [3:0]      r_out_idx, n_out_idx;
    logic            r_out_last, n_out_last;

    logic       in_acc, stall, adv, is_burst, item_last;
    logic [7:0] b, q8;
    logic [6:0] q;
    logic       in_burst, pack_lo, pack_hi, bit_v, wr_need;
    logic [3:0] wr_idx;
    logic [7:0] wr_data;
    logic [8:0] s0, s1, s2;

    always_comb begin
        b        = r_cnt - gbd_pkg::HEADER_LEN;
        in_burst = (r_cnt >= gbd_pkg::HEADER_LEN) && (r_cnt < gbd_pkg::DATAGRAM_LEN);
        pack_lo  = (b >= gbd_pkg::PACK_LO_FIRST) && (b <= gbd_pkg::PACK_LO_LAST);
        pack_hi  = (b >= gbd_pkg::PACK_HI_FIRST) && (b <= gbd_pkg::PACK_HI_LAST);
        q8       = pack_lo ? (b - gbd_pkg::PACK_LO_FIRST) : (b - gbd_pkg::PACK_HI_SHIFT);
        q        = q8[6:0];
        bit_v    = |i_s_tdata;
        n_acc    = {r_acc[6:0], bit_v};
        wr_need  = in_burst && (pack_lo || pack_hi)
                   && ((q[2:0] == 3'd7) || (q == gbd_pkg::PACK_LAST_BIT));
        wr_idx   = q[6:3];
        wr_data  = (q == gbd_pkg::PACK_LAST_BIT) ? {n_acc[3:0], 4'h0} : n_acc;

        adv       = !r_out_vld || i_m_tready;
        is_burst  = (r_job_st == gbd_pkg::ST_BURST);
        item_last = !is_burst || (r_rd_idx == gbd_pkg::PACK_LAST_IDX);

        stall = r_job_vld && ((i_s_tlast && !(adv && item_last))
                || (wr_need && (r_job_st == gbd_pkg::ST_BURST) && (wr_idx >= r_rd_idx)));
        o_s_tready  = !stall;
        in_acc      = i_s_tvalid && !stall;
        o_cfg_ready = 1'b1;

        s0 = {3'b000, r_mod} + {1'b0, i_s_tdata};
        s1 = (s0 >= gbd_pkg::MOD51_X3) ? (s0 - gbd_pkg::MOD51_X3) : s0;
        s2 = (s1 >= gbd_pkg::MOD51_X2) ? (s1 - gbd_pkg::MOD51_X2) : s1;
        if (s2 >= gbd_pkg::MOD51_X1) begin
            s2 = s2 - gbd_pkg::MOD51_X1;
        end

        n_cnt   = (r_cnt == gbd_pkg::BYTE_MAX) ? r_cnt : r_cnt + 8'd1;
        n_slot  = r_slot;
        n_fn    = r_fn;
        n_mod   = r_mod;
        n_pwr   = r_pwr;
        n_dummy = r_dummy;
        if (r_cnt == 8'd0) begin
            n_slot = i_s_tdata;
        end else if (r_cnt <= 8'd4) begin
            n_fn  = {r_fn[23:0], i_s_tdata};
            n_mod = s2[5:0];
        end else if (r_cnt == 8'd5) begin
            n_pwr = i_s_tdata;
        end else if (in_burst) begin
            if (i_s_tdata != {7'd0, gbd_pkg::DUMMY_BITS[b]}) begin
                n_dummy = 1'b0;
            end
        end

        if (n_cnt != gbd_pkg::DATAGRAM_LEN) begin
            n_job_st = gbd_pkg::ST_BAD_LEN;
        end else if (gbd_pkg::is_fcch_sch(n_mod)) begin
            n_job_st = gbd_pkg::ST_FCCH_SCH;
        end else if (n_dummy) begin
            n_job_st = gbd_pkg::ST_DUMMY;
        end else if (n_slot != {5'd0, r_ts}) begin
            n_job_st = gbd_pkg::ST_OTHER_TS;
        end else begin
            n_job_st = gbd_pkg::ST_BURST;
        end
        n_job_fn   = n_fn;
        n_job_slot = n_slot;
        n_job_pwr  = n_pwr;

        n_out_vld  = r_out_vld;
        n_out_st   = r_out_st;
        n_out_fn   = r_out_fn;
        n_out_slot = r_out_slot;
        n_out_pwr  = r_out_pwr;
        n_out_byte = r_out_byte;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;
        n_rd_idx   = r_rd_idx;
        n_job_vld  = r_job_vld;
        if (adv) begin
            n_out_vld = r_job_vld;
            if (r_job_vld) begin
                n_out_st   = r_job_st;
                n_out_fn   = r_job_fn;
                n_out_slot = r_job_slot;
                n_out_pwr  = r_job_pwr;
                n_out_byte = is_burst ? r_mem_q : 8'd0;
                n_out_idx  = is_burst ? r_rd_idx : 4'd0;
                n_out_last = item_last;
                if (item_last) begin
                    n_job_vld = 1'b0;
                    n_rd_idx  = 4'd0;
                end else begin
                    n_rd_idx = r_rd_idx + 4'd1;
                end
            end
        end
        if (in_acc && i_s_tlast) begin
            n_job_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && wr_need) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_mem_q <= r_mem[n_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts      <= 3'd0;
            r_cnt     <= 8'd0;
            r_slot    <= 8'd0;
            r_fn      <= 32'd0;
            r_mod     <= 6'd0;
            r_pwr     <= 8'd0;
            r_dummy   <= 1'b1;
            r_job_vld <= 1'b0;
            r_rd_idx  <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ts <= i_cfg_data;
            end
            if (in_acc) begin
                if (i_s_tlast) begin
                    r_cnt   <= 8'd0;
                    r_slot  <= 8'd0;
                    r_fn    <= 32'd0;
                    r_mod   <= 6'd0;
                    r_pwr   <= 8'd0;
                    r_dummy <= 1'b1;
                end else begin
                    r_cnt   <= n_cnt;
                    r_slot  <= n_slot;
                    r_fn    <= n_fn;
                    r_mod   <= n_mod;
                    r_pwr   <= n_pwr;
                    r_dummy <= n_dummy;
                end
            end
            r_job_vld <= n_job_vld;
            r_rd_idx  <= n_rd_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_burst && (pack_lo || pack_hi)) begin
            r_acc <= n_acc;
        end
        if (in_acc && i_s_tlast) begin
            r_job_st   <= n_job_st;
            r_job_fn   <= n_job_fn;
            r_job_slot <= n_job_slot;
            r_job_pwr  <= n_job_pwr;
        end
        r_out_st   <= n_out_st;
        r_out_fn   <= n_out_fn;
        r_out_slot <= n_out_slot;
        r_out_pwr  <= n_out_pwr;
        r_out_byte <= n_out_byte;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'h0, r_out_idx, r_out_byte, r_out_pwr, r_out_slot, r_out_fn};
    assign o_m_tuser  = r_out_st;
    assign o_m_tlast  = r_out_last;

endmodule
